@@ design/bsrch_pkg.sv @@
// Shared types and constants for the sorted-table binary search block.
package bsrch_pkg;

   localparam int POS_W   = 10;  // table position / match index width
   localparam int VAL_W   = 32;  // entry and key width
   localparam int COUNT_W = 11;  // entry_count register width
   localparam int BND_W   = 12;  // search bounds, hold 0 .. 2048
   localparam int MID_W   = 11;  // probe index, below 2047

   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_SEARCH = 1'b1;

   typedef struct packed {
      logic                    mode;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] match_index;
   } rsp_type;

   // handshake from front queue to back engine
   typedef struct packed {
      logic valid;
      logic pop;
   } queue_ctl_type;

endpackage

@@ design/bsrch_front.sv @@
// Front end: accepts transactions, drops out-of-range loads, queues the rest.
module bsrch_front import bsrch_pkg::*; #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    q_valid,
   output req_type q_item,
   input  logic    q_pop
);

   req_type     q_mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  fill_ff, fill_in;
   logic        accept;
   logic        keep;
   logic        push;
   logic        pop;

   assign busy    = (fill_ff == 2'd2);
   assign accept  = start && !busy;
   // a load outside the table is taken and discarded here
   assign keep    = (req_data.mode == MODE_SEARCH) ||
                    (32'(req_data.position) < 32'(TABLE_DEPTH));
   assign push    = accept && keep;
   assign q_valid = (fill_ff != 2'd0);
   assign pop     = q_pop && q_valid;
   assign q_item  = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule

@@ design/bsrch_back.sv @@
// Back end: table memory, loads, and the one-probe-per-cycle search engine.
module bsrch_back import bsrch_pkg::*; #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  queue_ctl_type      q_ctl_i,
   output logic               q_pop,
   input  req_type            q_item,
   input  logic [COUNT_W-1:0] entry_count,
   output logic               rsp_valid,
   output rsp_type            rsp_data
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_SEARCH = 1'b1;

   logic signed [VAL_W-1:0] table_mem [TABLE_DEPTH];

   logic                    state_ff, state_in;
   logic [BND_W-1:0]        lo_ff, lo_in;
   logic [BND_W-1:0]        hp1_ff, hp1_in;   // exclusive upper bound
   logic [MID_W-1:0]        mid_ff, mid_in;
   logic signed [VAL_W-1:0] key_ff, key_in;
   logic signed [VAL_W-1:0] rd_data_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    rd_en;
   logic                    wr_en;
   logic [BND_W-1:0]        count_clamped;
   logic [BND_W-1:0]        lo_n, hp1_n, sum_n;

   assign q_pop     = (state_ff == ST_IDLE) && q_ctl_i.valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      if (32'(entry_count) > 32'(TABLE_DEPTH)) begin
         count_clamped = BND_W'(TABLE_DEPTH);
      end else begin
         count_clamped = BND_W'(entry_count);
      end
   end

   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hp1_in       = hp1_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      lo_n         = lo_ff;
      hp1_n        = hp1_ff;
      sum_n        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               if (q_item.mode == MODE_LOAD) begin
                  wr_en = 1'b1;
               end else begin
                  key_in = q_item.value;
                  lo_in  = '0;
                  hp1_in = count_clamped;
                  if (count_clamped == '0) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{found: 1'b0, match_index: '0};
                  end else begin
                     sum_n    = count_clamped - BND_W'(1);
                     mid_in   = sum_n[MID_W:1];
                     rd_en    = 1'b1;
                     state_in = ST_SEARCH;
                  end
               end
            end
         end
         ST_SEARCH: begin
            if (rd_data_ff == key_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{found: 1'b1, match_index: mid_ff[POS_W-1:0]};
               state_in     = ST_IDLE;
            end else begin
               if (rd_data_ff < key_ff) begin
                  lo_n = BND_W'(mid_ff) + BND_W'(1);
               end else begin
                  hp1_n = BND_W'(mid_ff);
               end
               lo_in  = lo_n;
               hp1_in = hp1_n;
               if (lo_n >= hp1_n) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{found: 1'b0, match_index: '0};
                  state_in     = ST_IDLE;
               end else begin
                  // floor of (lo + hi) / 2 with hi = hp1 - 1
                  sum_n  = lo_n + hp1_n - BND_W'(1);
                  mid_in = sum_n[MID_W:1];
                  rd_en  = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hp1_ff <= hp1_in;
      mid_ff <= mid_in;
      key_ff <= key_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[AW'(q_item.position)] <= q_item.value;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_mem[AW'(mid_in)];
      end
   end

endmodule

@@ design/sorted_table_binary_search.sv @@
// A search result strobes from the result register after the engine pops it from the
// queue: with no table probe for an empty range, else once the last probe resolves it.
// Loads are written one per cycle while the engine is idle; a search holds the engine
// until it ends, one probe per cycle on the table memory's single read port.
// Reset clears the queue, engine state, result strobe and entry_count; table
// contents are undefined until loaded. The receiver cannot stall results.
module sorted_table_binary_search import bsrch_pkg::*; #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_data,
   output logic               rsp_valid,
   output rsp_type            rsp_data,
   input  logic               csr_we,
   input  logic [COUNT_W-1:0] csr_wdata
);

   logic [COUNT_W-1:0] entry_count_ff;
   queue_ctl_type      q_ctl;
   logic               q_valid;
   logic               q_pop;
   req_type            q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (csr_we) begin
         entry_count_ff <= csr_wdata;
      end
   end

   assign q_ctl.valid = q_valid;
   assign q_ctl.pop   = q_pop;

   bsrch_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .busy     (busy),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_ctl.pop)
   );

   bsrch_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_ctl_i     (q_ctl),
      .q_pop       (q_pop),
      .q_item      (q_item),
      .entry_count (entry_count_ff),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

@@ design/bsrch_checker.sv @@
// Port-level checker for the sorted-table binary search block, with its bind.
module bsrch_checker import bsrch_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input req_type            req_data,
   input logic               rsp_valid,
   input rsp_type            rsp_data,
   input logic               csr_we,
   input logic [COUNT_W-1:0] csr_wdata
);

   // reset leaves no result in flight and the queue open
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !busy)
      else $error("result or busy seen right after reset");

   // a miss always reports index zero
   a_miss_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.match_index == '0)
      else $error("miss reported with nonzero index");

   // the queue only fills through an accepted transaction
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && !busy))
      else $error("busy rose without an accepted transaction");

   // a result never strobes in the cycle right after reset
   a_no_rsp_post_reset: assert property (@(posedge clock)
      rsp_valid |-> !$past(reset))
      else $error("result strobed right after reset");

endmodule

bind sorted_table_binary_search bsrch_checker u_bsrch_checker (.*);
